// ===== rtl/pva_pkg.sv =====
// Shared types, function codes and field widths for the polyphonic voice allocator.
`default_nettype none
package pva_pkg;

	// Fixed field widths of the request and result items.
	localparam int FUNC_W  = 3;
	localparam int NOTE_W  = 7;
	localparam int CHAN_W  = 4;
	localparam int VSEL_W  = 3;
	localparam int AVOX_W  = 3;
	localparam int MASK_W  = 8;
	localparam int STAMP_W = 32;

	// Request data and result data widths on the stream buses.
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 16;

	// Default geometry.
	localparam int DEF_VOICES = 8;
	localparam int DEF_BANKS  = 2;

	// Function codes carried in the request's tuser.
	localparam logic [FUNC_W-1:0] FN_NOTE_ON  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_NOTE_OFF = 3'd1;
	localparam logic [FUNC_W-1:0] FN_LEVEL    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_TICK     = 3'd3;
	localparam logic [FUNC_W-1:0] FN_PANIC    = 3'd4;

	// One stored voice entry.
	typedef struct packed {
		logic [NOTE_W-1:0]  note;
		logic [CHAN_W-1:0]  chan;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// Per-step control handed from the sequencer to the scan unit.
	typedef struct packed {
		logic clear;
		logic step;
		logic held;
		logic sounding;
	} scan_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/pva_entry_mem.sv =====
// Voice entry memory: one write port and one registered read port.
`default_nettype none
module pva_entry_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire pva_pkg::entry_t wdata,
	input  wire logic            re,
	input  wire logic [AW-1:0]   raddr,
	output pva_pkg::entry_t      rdata
);
	import pva_pkg::*;

	entry_t mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pva_scan_unit.sv =====
// Shared scan unit: tracks the first free voice and the oldest voice, one voice per step.
`default_nettype none
module pva_scan_unit #(
	parameter int VOICES = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pva_pkg::scan_ctl_t              ctl,
	input  wire logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] idx,
	input  wire pva_pkg::entry_t                 ent,
	input  wire logic                            stamp_ok,
	input  wire logic [pva_pkg::STAMP_W-1:0]     now,
	input  wire logic [pva_pkg::NOTE_W-1:0]      note,
	input  wire logic [pva_pkg::CHAN_W-1:0]      chan,
	output logic                                 found_free,
	output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] free_idx,
	output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] best_idx,
	output logic                                 match
);
	import pva_pkg::*;

	localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

	logic [STAMP_W-1:0] stamp_eff;
	logic [STAMP_W-1:0] age;
	logic [STAMP_W-1:0] best_age_q;
	logic               found_q;
	logic [VIDX_W-1:0]  free_q;
	logic [VIDX_W-1:0]  best_q;

	// A stamp never written since reset reads as zero.
	assign stamp_eff = stamp_ok ? ent.stamp : '0;
	assign age       = now - stamp_eff;
	assign match     = (ent.note == note) && (ent.chan == chan);

	// Running first-free and largest-age trackers; ties keep the lower index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			free_q     <= '0;
			best_q     <= '0;
			best_age_q <= '0;
		end else if (ctl.clear) begin
			found_q    <= 1'b0;
			free_q     <= '0;
			best_q     <= '0;
			best_age_q <= '0;
		end else if (ctl.step) begin
			if (!found_q && !ctl.held && !ctl.sounding) begin
				found_q <= 1'b1;
				free_q  <= idx;
			end
			if (age > best_age_q) begin
				best_age_q <= age;
				best_q     <= idx;
			end
		end
	end

	assign found_free = found_q;
	assign free_idx   = free_q;
	assign best_idx   = best_q;

endmodule
`default_nettype wire

// ===== rtl/polyphonic_voice_allocator_unit.sv =====
// Polyphonic voice allocator: sequencer, voice flags and tick counter around the scan unit.
//
// Usage:
//   Requests enter on the s_ group (tvalid/tready/tdata/tuser). tuser carries the
//   function code; tdata carries bank, note, channel, silent flag, voice select and
//   level flag. Every request yields exactly one result on the m_ group, holding the
//   allocation flag, allocated voice, steal flag and the note-off release mask.
//   Note-on and note-off walk the addressed bank one voice per cycle through the
//   shared scan unit, reading the entry memory; after the scan and last-read steps
//   the result is registered in the final step and offered, and s_tready rises in
//   that same cycle, so the next request can be taken while the result waits. Level
//   updates, ticks, panic and ignored requests go straight to the final step.
//   The block takes one request at a time; s_tready is low while one is in work.
//   If the receiver holds m_tready low, the result stays on the output register; a
//   following request waits in its final step until that result is taken.
//   Reset clears all held and sounding flags, the stamp valid bits, the tick count
//   and the output; no clearing pass is needed, and s_tready is high right after.
`default_nettype none
module polyphonic_voice_allocator_unit #(
	parameter int VOICES = pva_pkg::DEF_VOICES,
	parameter int BANKS  = pva_pkg::DEF_BANKS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// bank[0], note[7:1], chan[11:8], silent[12], voice_sel[15:13],
	// level_nonzero[16], zero fill[23:17]
	input  wire logic [pva_pkg::S_DATA_W-1:0]  s_tdata,
	// func[2:0]
	input  wire logic [pva_pkg::FUNC_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// assigned_valid[0], assigned_voice[3:1], stolen[4], released_mask[12:5],
	// zero fill[15:13]
	output logic [pva_pkg::M_DATA_W-1:0]       m_tdata
);
	import pva_pkg::*;

	localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SLOTS  = BANKS * VOICES;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LAST, ST_DONE} state_t;
	typedef enum logic [1:0] {RES_NONE, RES_ON, RES_OFF} kind_t;

	state_t             state_q;
	kind_t              kind_q;
	logic [SLOTS-1:0]   held_q;
	logic [SLOTS-1:0]   sounding_q;
	logic [SLOTS-1:0]   stamp_ok_q;
	logic [STAMP_W-1:0] now_q;
	logic               bank_q;
	logic [NOTE_W-1:0]  note_q;
	logic [CHAN_W-1:0]  chan_q;
	logic [VIDX_W-1:0]  idx_q;
	logic [MASK_W-1:0]  mask_q;
	logic               rd_vld_s1;
	logic [VIDX_W-1:0]  idx_s1;
	logic               stamp_ok_s1;
	logic               m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	// Request fields.
	logic [FUNC_W-1:0]  in_func;
	logic               in_bank;
	logic [NOTE_W-1:0]  in_note;
	logic [CHAN_W-1:0]  in_chan;
	logic               in_silent;
	logic [VSEL_W-1:0]  in_vsel;
	logic               in_level;
	logic               in_bank_ok;
	logic               in_vsel_ok;
	logic [SLOT_W-1:0]  in_lvl_slot;
	logic               start_on;
	logic               start_off;

	logic               accept;
	logic               push;
	logic               commit_on;
	logic [SLOT_W-1:0]  rd_slot;
	logic [SLOT_W-1:0]  s1_slot;
	logic [SLOT_W-1:0]  wr_slot;
	logic [VIDX_W-1:0]  sel_idx;
	entry_t             wr_ent;
	entry_t             rd_ent;
	scan_ctl_t          scan_ctl;
	logic               found_free;
	logic [VIDX_W-1:0]  free_idx;
	logic [VIDX_W-1:0]  best_idx;
	logic               match;

	// Slot address of a voice within a bank.
	function automatic logic [SLOT_W-1:0] slot_of(input logic bank, input int v);
		slot_of = SLOT_W'(bank ? (VOICES + v) : v);
	endfunction

	// Unpack the request.
	assign in_func     = s_tuser;
	assign in_bank     = s_tdata[0];
	assign in_note     = s_tdata[7:1];
	assign in_chan     = s_tdata[11:8];
	assign in_silent   = s_tdata[12];
	assign in_vsel     = s_tdata[15:13];
	assign in_level    = s_tdata[16];
	assign in_bank_ok  = (int'(in_bank) < BANKS);
	assign in_vsel_ok  = (int'(in_vsel) < VOICES);
	assign in_lvl_slot = slot_of(in_bank, int'(in_vsel));

	// Note events that pass the bank and silent checks go through the voice scan.
	assign start_on  = (in_func == FN_NOTE_ON) && in_bank_ok && !in_silent;
	assign start_off = (in_func == FN_NOTE_OFF) && in_bank_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign push     = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// Addressing for the scan read, the scan step and the allocation write.
	assign rd_slot   = slot_of(bank_q, int'(idx_q));
	assign s1_slot   = slot_of(bank_q, int'(idx_s1));
	assign sel_idx   = found_free ? free_idx : best_idx;
	assign wr_slot   = slot_of(bank_q, int'(sel_idx));
	assign commit_on = push && (kind_q == RES_ON);
	assign wr_ent    = '{note: note_q, chan: chan_q, stamp: now_q};

	assign scan_ctl = '{
		clear:    accept,
		step:     rd_vld_s1,
		held:     held_q[s1_slot],
		sounding: sounding_q[s1_slot]
	};

	pva_entry_mem #(
		.DEPTH (SLOTS),
		.AW    (SLOT_W)
	) u_mem (
		.clk   (clk),
		.we    (commit_on),
		.waddr (wr_slot),
		.wdata (wr_ent),
		.re    (state_q == ST_SCAN),
		.raddr (rd_slot),
		.rdata (rd_ent)
	);

	pva_scan_unit #(
		.VOICES (VOICES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.idx        (idx_s1),
		.ent        (rd_ent),
		.stamp_ok   (stamp_ok_s1),
		.now        (now_q),
		.note       (note_q),
		.chan       (chan_q),
		.found_free (found_free),
		.free_idx   (free_idx),
		.best_idx   (best_idx),
		.match      (match)
	);

	// Sequencer, voice flags, tick counter and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= RES_NONE;
			held_q      <= '0;
			sounding_q  <= '0;
			stamp_ok_q  <= '0;
			now_q       <= '0;
			bank_q      <= 1'b0;
			note_q      <= '0;
			chan_q      <= '0;
			idx_q       <= '0;
			mask_q      <= '0;
			rd_vld_s1   <= 1'b0;
			idx_s1      <= '0;
			stamp_ok_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			// The result is offered when pushed and withdrawn once taken.
			if (push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			// Note-off releases a matching held voice as the scan passes it.
			if (rd_vld_s1 && (kind_q == RES_OFF) && held_q[s1_slot] && match) begin
				held_q[s1_slot] <= 1'b0;
				mask_q          <= mask_q | (MASK_W'(1) << idx_s1);
			end

			unique case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (accept) begin
						bank_q <= in_bank;
						note_q <= in_note;
						chan_q <= in_chan;
						idx_q  <= '0;
						mask_q <= '0;
						if (start_on) begin
							kind_q  <= RES_ON;
							state_q <= ST_SCAN;
						end else if (start_off) begin
							kind_q  <= RES_OFF;
							state_q <= ST_SCAN;
						end else begin
							kind_q  <= RES_NONE;
							state_q <= ST_DONE;
						end
						unique case (in_func)
							FN_LEVEL: begin
								if (in_bank_ok && in_vsel_ok) begin
									sounding_q[in_lvl_slot] <= in_level;
								end
							end
							FN_TICK: begin
								now_q <= now_q + STAMP_W'(1);
							end
							FN_PANIC: begin
								held_q     <= '0;
								sounding_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					rd_vld_s1   <= 1'b1;
					idx_s1      <= idx_q;
					stamp_ok_s1 <= stamp_ok_q[rd_slot];
					if (idx_q == VIDX_W'(VOICES - 1)) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + VIDX_W'(1);
					end
				end
				ST_LAST: begin
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					rd_vld_s1 <= 1'b0;
					if (push) begin
						state_q <= ST_IDLE;
						unique case (kind_q)
							RES_ON: begin
								held_q[wr_slot]     <= 1'b1;
								sounding_q[wr_slot] <= 1'b0;
								stamp_ok_q[wr_slot] <= 1'b1;
								m_tdata_q <= {3'b000, 8'h00, !found_free,
									AVOX_W'(sel_idx), 1'b1};
							end
							RES_OFF: begin
								m_tdata_q <= {3'b000, mask_q, 1'b0, 3'b000, 1'b0};
							end
							default: begin
								m_tdata_q <= '0;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// ===== rtl/pva_checker.sv =====
// Port-level checker for the voice allocator and its bind to the top level.
`default_nettype none
module pva_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_tvalid,
	input wire logic                         s_tready,
	input wire logic                         m_tvalid,
	input wire logic                         m_tready,
	input wire logic [pva_pkg::M_DATA_W-1:0] m_tdata
);
	import pva_pkg::*;

	// A result that is not taken stays offered.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// The block works on one request at a time.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	// Without an allocation, voice and steal fields are zero.
	a_no_alloc_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
		else $error("voice fields set without allocation");

	// An allocation never releases voices in the same result.
	a_alloc_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[12:5] == 8'd0)
		else $error("release mask set on allocation");

endmodule

bind polyphonic_voice_allocator_unit pva_checker u_pva_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/sv/polyphonic_voice_allocator_unit_tb.sv =====
// Self-checking testbench for the polyphonic voice allocator: directed table, then random requests.
`timescale 1ns / 1ps
module polyphonic_voice_allocator_unit_tb;
	import pva_pkg::*;

	localparam int NV = DEF_VOICES;
	localparam int NB = DEF_BANKS;
	localparam int SLOT_N = NV * NB;
	localparam int RANDOM_N = 1700;
	localparam int DRAIN_CYCLES = 2 * (NV + 3);

	// Function codes the block treats as no-ops.
	localparam logic [FUNC_W-1:0] FN_SPARE_5 = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

	// Request data as it sits on s_tdata, lowest field last.
	typedef struct packed {
		logic [6:0]        fill;
		logic              lvl;
		logic [VSEL_W-1:0] vsel;
		logic              silent;
		logic [CHAN_W-1:0] chan;
		logic [NOTE_W-1:0] note;
		logic              bank;
	} voice_req_t;

	// Result data as it sits on m_tdata, lowest field last.
	typedef struct packed {
		logic [2:0]        fill;
		logic [MASK_W-1:0] mask;
		logic              stolen;
		logic [AVOX_W-1:0] voice;
		logic              valid;
	} voice_result_t;

	// One row of the directed stimulus table.
	typedef struct {
		logic [FUNC_W-1:0] fn;
		voice_req_t        req;
		bit                typed;
		voice_result_t     want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [FUNC_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	// Shadow copy of the voice banks.
	logic              shadow_held [SLOT_N];
	logic              shadow_sounding [SLOT_N];
	logic [NOTE_W-1:0] shadow_note [SLOT_N];
	logic [CHAN_W-1:0] shadow_chan [SLOT_N];
	logic [31:0]       shadow_stamp [SLOT_N];
	logic [31:0]       shadow_ticks;

	voice_result_t pending_results[$];
	stim_row_t directed_rows[$];

	int errors = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int allocs_seen = 0;
	int steals_seen = 0;
	int releases_seen = 0;
	int panics_sent = 0;

	polyphonic_voice_allocator_unit #(
		.VOICES(NV),
		.BANKS(NB)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Applies one request to the shadow banks and returns the result it should produce.
	function automatic voice_result_t allocate_voice(input logic [FUNC_W-1:0] fn,
			input voice_req_t r);
		voice_result_t res;
		int base;
		int pick;
		int s;
		bit found;
		logic [31:0] age;
		logic [31:0] best_age;
		res = '0;
		base = r.bank * NV;
		pick = 0;
		found = 1'b0;
		case (fn)
			FN_NOTE_ON: begin
				if (r.bank < NB && !r.silent) begin
					// A free voice wins; otherwise the oldest one is taken over.
					for (int v = 0; v < NV; v++) begin
						if (!found && !shadow_held[base + v] &&
								!shadow_sounding[base + v]) begin
							found = 1'b1;
							pick = v;
						end
					end
					if (!found) begin
						best_age = '0;
						for (int v = 0; v < NV; v++) begin
							age = shadow_ticks - shadow_stamp[base + v];
							if (age > best_age) begin
								best_age = age;
								pick = v;
							end
						end
					end
					s = base + pick;
					shadow_held[s] = 1'b1;
					shadow_sounding[s] = 1'b0;
					shadow_note[s] = r.note;
					shadow_chan[s] = r.chan;
					shadow_stamp[s] = shadow_ticks;
					res.valid = 1'b1;
					res.voice = pick[AVOX_W-1:0];
					res.stolen = !found;
				end
			end
			FN_NOTE_OFF: begin
				if (r.bank < NB) begin
					for (int v = 0; v < NV; v++) begin
						s = base + v;
						if (shadow_held[s] && shadow_chan[s] == r.chan &&
								shadow_note[s] == r.note) begin
							shadow_held[s] = 1'b0;
							if (v < MASK_W) res.mask[v] = 1'b1;
						end
					end
				end
			end
			FN_LEVEL: begin
				if (r.bank < NB && r.vsel < NV) shadow_sounding[base + r.vsel] = r.lvl;
			end
			FN_TICK: begin
				shadow_ticks = shadow_ticks + 32'd1;
			end
			FN_PANIC: begin
				for (int k = 0; k < SLOT_N; k++) begin
					shadow_held[k] = 1'b0;
					shadow_sounding[k] = 1'b0;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Adds one row to the directed table; typed rows carry their own expected result.
	task automatic add_row(input logic [FUNC_W-1:0] fn, input logic bank,
			input logic [NOTE_W-1:0] note, input logic [CHAN_W-1:0] chan, input logic silent,
			input logic [VSEL_W-1:0] vsel, input logic lvl, input bit typed,
			input logic avalid, input logic [AVOX_W-1:0] avoice, input logic stolen,
			input logic [MASK_W-1:0] mask);
		stim_row_t row;
		row.fn = fn;
		row.req = '0;
		row.req.bank = bank;
		row.req.note = note;
		row.req.chan = chan;
		row.req.silent = silent;
		row.req.vsel = vsel;
		row.req.lvl = lvl;
		row.typed = typed;
		row.want = '0;
		row.want.valid = avalid;
		row.want.voice = avoice;
		row.want.stolen = stolen;
		row.want.mask = mask;
		directed_rows.push_back(row);
	endtask

	// Offers one request, waits for it to be taken and records the result it should produce.
	task automatic send_request(input logic [FUNC_W-1:0] fn, input voice_req_t r,
			input bit no_gap, input bit typed, input voice_result_t want);
		voice_result_t predicted;
		while (!no_gap && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= r;
		s_tuser <= fn;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = allocate_voice(fn, r);
		pending_results.push_back(typed ? want : predicted);
		requests_sent++;
		if (fn == FN_PANIC) panics_sent++;
	endtask

	// Result monitor and receiver backpressure.
	int stall_left = 0;
	bit long_stall_done = 1'b0;
	always @(posedge clk) begin
		voice_result_t got;
		voice_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					errors++;
					$display("%0t: result %0d mismatch: expected %h, got %h",
						$time, results_seen, want, got);
				end
			end
			if (got.valid) allocs_seen++;
			if (got.stolen) steals_seen++;
			releases_seen += $countones(got.mask);
			results_seen++;
		end
		// One long hold-off fills the block; a quiet window follows later.
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!long_stall_done && results_seen == 400) begin
			long_stall_done = 1'b1;
			stall_left = 300;
			m_tready <= 1'b0;
		end else if (results_seen >= 700 && results_seen < 1000) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 38);
		end
	end

	// Reset, directed table, random requests and the end of the run.
	initial begin
		voice_req_t rq;
		logic [FUNC_W-1:0] fn;
		int unsigned pick;
		for (int k = 0; k < SLOT_N; k++) begin
			shadow_held[k] = 1'b0;
			shadow_sounding[k] = 1'b0;
			shadow_note[k] = '0;
			shadow_chan[k] = '0;
			shadow_stamp[k] = '0;
		end
		shadow_ticks = '0;

		// First allocations after reset, silent and unmatched requests, level, tick, spare codes and panic.
		add_row(FN_NOTE_ON, 1'b0, 7'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1, 1'b1, 3'd0, 1'b0, 8'h00);
		add_row(FN_NOTE_ON, 1'b0, 7'd127, 4'd15, 1'b0, 3'd0, 1'b0, 1, 1'b1, 3'd1, 1'b0, 8'h00);
		add_row(FN_NOTE_ON, 1'b0, 7'd10, 4'd3, 1'b1, 3'd0, 1'b0, 1, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_NOTE_OFF, 1'b0, 7'd127, 4'd15, 1'b0, 3'd0, 1'b0, 1, 1'b0, 3'd0, 1'b0, 8'h02);
		add_row(FN_NOTE_OFF, 1'b0, 7'd5, 4'd5, 1'b0, 3'd0, 1'b0, 1, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_LEVEL, 1'b0, 7'd0, 4'd0, 1'b0, 3'd7, 1'b1, 1, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_LEVEL, 1'b0, 7'd0, 4'd0, 1'b0, 3'd0, 1'b1, 1, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_TICK, 1'b1, 7'd127, 4'd15, 1'b1, 3'd7, 1'b1, 1, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_SPARE_5, 1'b0, 7'd1, 4'd1, 1'b0, 3'd0, 1'b0, 1, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_SPARE_6, 1'b1, 7'd2, 4'd2, 1'b0, 3'd1, 1'b1, 1, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_SPARE_7, 1'b0, 7'd3, 4'd3, 1'b1, 3'd2, 1'b0, 1, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_NOTE_ON, 1'b0, 7'd64, 4'd8, 1'b0, 3'd0, 1'b0, 0, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_NOTE_OFF, 1'b0, 7'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1, 1'b0, 3'd0, 1'b0, 8'h01);
		add_row(FN_LEVEL, 1'b1, 7'd0, 4'd0, 1'b0, 3'd3, 1'b1, 1, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_PANIC, 1'b0, 7'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_NOTE_ON, 1'b1, 7'd64, 4'd8, 1'b0, 3'd0, 1'b0, 1, 1'b1, 3'd0, 1'b0, 8'h00);
		// Fill bank 1, then steal with all ages at zero and again after a tick.
		for (int k = 0; k < NV - 1; k++) begin
			pick = 65 + k;
			add_row(FN_NOTE_ON, 1'b1, pick[NOTE_W-1:0], pick[CHAN_W-1:0], 1'b0, 3'd0, 1'b0, 0,
				1'b0, 3'd0, 1'b0, 8'h00);
		end
		add_row(FN_NOTE_ON, 1'b1, 7'd100, 4'd9, 1'b0, 3'd0, 1'b0, 0, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_TICK, 1'b0, 7'd0, 4'd0, 1'b0, 3'd0, 1'b0, 1, 1'b0, 3'd0, 1'b0, 8'h00);
		add_row(FN_NOTE_ON, 1'b1, 7'd101, 4'd10, 1'b0, 3'd0, 1'b0, 0, 1'b0, 3'd0, 1'b0, 8'h00);

		// Hold reset, then release it.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].fn, directed_rows[i].req, 1'b0,
				directed_rows[i].typed, directed_rows[i].want);

		// Random requests: mostly note traffic over a small pool so note-offs match.
		for (int i = 0; i < RANDOM_N; i++) begin
			if (i == 1200) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(99);
			if (pick < 36) fn = FN_NOTE_ON;
			else if (pick < 60) fn = FN_NOTE_OFF;
			else if (pick < 80) fn = FN_LEVEL;
			else if (pick < 93) fn = FN_TICK;
			else if (pick < 95) fn = FN_PANIC;
			else if (pick < 97) fn = FN_SPARE_5;
			else if (pick < 98) fn = FN_SPARE_6;
			else fn = FN_SPARE_7;
			rq = '0;
			rq.bank = 1'($urandom_range(1));
			if ($urandom_range(3) != 0) pick = 60 + $urandom_range(3);
			else pick = $urandom_range(127);
			rq.note = pick[NOTE_W-1:0];
			if ($urandom_range(3) != 0) pick = $urandom_range(1);
			else pick = $urandom_range(15);
			rq.chan = pick[CHAN_W-1:0];
			rq.silent = ($urandom_range(9) == 0);
			pick = $urandom_range(7);
			rq.vsel = pick[VSEL_W-1:0];
			rq.lvl = ($urandom_range(9) < 6);
			send_request(fn, rq, (i >= 700 && i < 1000), 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// Drain the outstanding results, then keep watching for stray results before the summary.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d requests (%0d directed), %0d panics; checked %0d results.",
			requests_sent, directed_rows.size(), panics_sent, results_seen);
		$display("Saw %0d voice allocations, %0d of them steals, and %0d voice releases.",
			allocs_seen, steals_seen, releases_seen);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS polyphonic_voice_allocator_unit");
		end else begin
			$display("FAIL polyphonic_voice_allocator_unit");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("FAIL polyphonic_voice_allocator_unit");
		$finish;
	end

endmodule
